[design/lsr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lsr_pkg;

	typedef struct packed {
		logic        func;
		logic [31:0] voxel_value;
	} src_t;

	typedef struct packed {
		logic [31:0] new_value;
		logic        last_voxel;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DIFF,
		ST_TERM,
		ST_ROOT,
		ST_SCALE,
		ST_OUT
	} state_t;

	localparam logic FUNC_PUSH  = 1'b0;
	localparam logic FUNC_FLUSH = 1'b1;

	localparam logic [2:0] REG_SIZE_X      = 3'd0;
	localparam logic [2:0] REG_SIZE_Y      = 3'd1;
	localparam logic [2:0] REG_SIZE_Z      = 3'd2;
	localparam logic [2:0] REG_INV_SPACING = 3'd3;
	localparam logic [2:0] REG_TIME_STEP   = 3'd4;

	localparam logic [31:0] ONE_Q16 = 32'd65536;
	localparam logic [64:0] HALF_LSB = 65'h8000;

endpackage

`default_nettype wire

[design/level_set_reinit_step_3d.sv]
// Channel | Dir | Handshake          | Payload
// src     | in  | src_valid/src_stall | lsr_pkg::src_t (func, voxel_value)
// res     | out | res_valid/res_stall | lsr_pkg::res_t (new_value, last_voxel)
// cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
// A beat that causes no result does not hold the input. A beat that causes a result holds the input
// while the sequencer takes it, makes the seven window reads through the single RAM read port,
// forms the six scaled differences on one multiplier, forms the squares, runs the bit-serial
// square root, then scales and outputs the result.
// Reset clears the counters and the control; the window RAM is not cleared.
// The next beat is taken while a finished result waits behind res_stall; a second finished
// result holds the input until that beat is taken.
`timescale 1ns / 1ps
`default_nettype none

module level_set_reinit_step_3d #(
	parameter int MAX_X = 64,
	parameter int MAX_Y = 64,
	parameter int MAX_Z = 256
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          src_valid,
	output      logic          src_stall,
	input  wire lsr_pkg::src_t src_data,
	output      logic          res_valid,
	input  wire logic          res_stall,
	output      lsr_pkg::res_t res_data,
	input  wire logic          cfg_valid,
	output      logic          cfg_ready,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [31:0]   cfg_data
);

	localparam int W      = 2 * MAX_X * MAX_Y + 1;
	localparam int AW     = $clog2(W);
	localparam int XW     = $clog2(MAX_X + 1);
	localparam int YW     = $clog2(MAX_Y + 1);
	localparam int ZW     = $clog2(MAX_Z + 1);
	localparam int MNW    = $clog2(MAX_X * MAX_Y + 1);
	localparam int CW     = $clog2(MAX_X * MAX_Y * MAX_Z + 1);
	localparam int SX_RST = (64 > MAX_X) ? MAX_X : 64;
	localparam int SY_RST = (64 > MAX_Y) ? MAX_Y : 64;
	localparam int SZ_RST = (64 > MAX_Z) ? MAX_Z : 64;

	function automatic logic [31:0] clamp_size(input logic [31:0] v, input logic [31:0] hi);
		logic [31:0] r;
		if (v < 32'd2) begin
			r = 32'd2;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	logic [XW-1:0]  sx_q;
	logic [YW-1:0]  sy_q;
	logic [ZW-1:0]  sz_q;
	logic [MNW-1:0] mn;
	logic [CW-1:0]  total;
	logic [31:0]    inv_q;
	logic [31:0]    ts_q;

	logic [CW-1:0] pushed_q;
	logic [CW-1:0] emitted_q;
	logic [AW-1:0] wp_q;
	logic [AW-1:0] ep_q;
	logic [XW-1:0] ix_q;
	logic [YW-1:0] iy_q;
	logic [ZW-1:0] iz_q;

	logic [AW-1:0] pp_q;
	logic [XW-1:0] pi_q;
	logic [YW-1:0] pj_q;
	logic [ZW-1:0] pk_q;
	logic          plast_q;

	lsr_pkg::state_t state_q, state_d;
	logic [2:0]      cnt_q;

	logic [31:0]        nb_q [7];
	logic signed [32:0] sd_q [6];
	logic [63:0]        sq_q;
	logic [63:0]        sum_q;
	logic [48:0]        d_q;
	logic               hpos_q;

	logic          res_valid_q;
	lsr_pkg::res_t res_q;

	logic cfg_acc, size_wr, src_acc, is_push, push_ok, push_emit, flush_emit, emit;
	logic emit_last;

	assign mn    = MNW'(sx_q) * MNW'(sy_q);
	assign total = CW'(mn) * CW'(sz_q);

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign size_wr   = cfg_acc && (cfg_index == lsr_pkg::REG_SIZE_X ||
		cfg_index == lsr_pkg::REG_SIZE_Y || cfg_index == lsr_pkg::REG_SIZE_Z);

	assign src_acc    = src_valid && !src_stall;
	assign is_push    = (src_data.func == lsr_pkg::FUNC_PUSH);
	assign push_ok    = is_push && (pushed_q < total);
	assign push_emit  = push_ok && (pushed_q >= CW'(mn));
	assign flush_emit = !is_push && (pushed_q == total) && (emitted_q < total);
	assign emit       = push_emit || flush_emit;
	assign emit_last  = (emitted_q == total - CW'(1));

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q    <= XW'(SX_RST);
			sy_q    <= YW'(SY_RST);
			sz_q    <= ZW'(SZ_RST);
			inv_q   <= 32'd65536;
			ts_q    <= 32'd6554;
		end else begin
			if (cfg_acc) begin
				unique case (cfg_index)
					lsr_pkg::REG_SIZE_X:
						sx_q <= XW'(clamp_size({25'd0, cfg_data[6:0]}, 32'(MAX_X)));
					lsr_pkg::REG_SIZE_Y:
						sy_q <= YW'(clamp_size({25'd0, cfg_data[6:0]}, 32'(MAX_Y)));
					lsr_pkg::REG_SIZE_Z:
						sz_q <= ZW'(clamp_size({23'd0, cfg_data[8:0]}, 32'(MAX_Z)));
					lsr_pkg::REG_INV_SPACING: inv_q <= cfg_data;
					lsr_pkg::REG_TIME_STEP:   ts_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Volume counters and window pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pushed_q  <= '0;
			emitted_q <= '0;
			wp_q      <= '0;
			ep_q      <= '0;
			ix_q      <= '0;
			iy_q      <= '0;
			iz_q      <= '0;
		end else if (size_wr || (src_acc && flush_emit && emit_last)) begin
			pushed_q  <= '0;
			emitted_q <= '0;
			wp_q      <= '0;
			ep_q      <= '0;
			ix_q      <= '0;
			iy_q      <= '0;
			iz_q      <= '0;
		end else if (src_acc) begin
			if (push_ok) begin
				pushed_q <= pushed_q + CW'(1);
				wp_q     <= (wp_q == AW'(W - 1)) ? '0 : wp_q + AW'(1);
			end
			if (emit) begin
				emitted_q <= emitted_q + CW'(1);
				ep_q      <= (ep_q == AW'(W - 1)) ? '0 : ep_q + AW'(1);
				if (ix_q == sx_q - XW'(1)) begin
					ix_q <= '0;
					if (iy_q == sy_q - YW'(1)) begin
						iy_q <= '0;
						iz_q <= iz_q + ZW'(1);
					end else begin
						iy_q <= iy_q + YW'(1);
					end
				end else begin
					ix_q <= ix_q + XW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (src_acc && emit) begin
			pp_q    <= ep_q;
			pi_q    <= ix_q;
			pj_q    <= iy_q;
			pk_q    <= iz_q;
			plast_q <= emit_last;
		end
	end

	// Window reads: center, then the x, y and z neighbors below and above.
	logic [AW-1:0] off;
	logic [AW:0]   up_sum;
	logic [AW-1:0] up_addr;
	logic [AW-1:0] dn_addr;
	logic [AW-1:0] raddr;
	logic [31:0]   rdata;
	logic          ram_re;
	logic          sq_start;
	logic          sq_done;
	logic [31:0]   sq_root;

	always_comb begin
		unique case (cnt_q)
			3'd1, 3'd2: off = AW'(1);
			3'd3, 3'd4: off = AW'(sx_q);
			3'd5, 3'd6: off = AW'(mn);
			default:    off = '0;
		endcase
		up_sum  = {1'b0, pp_q} + {1'b0, off};
		up_addr = (up_sum >= (AW + 1)'(W)) ? AW'(up_sum - (AW + 1)'(W)) : AW'(up_sum);
		dn_addr = (pp_q >= off) ? pp_q - off : AW'((AW + 1)'(pp_q) + (AW + 1)'(W) - (AW + 1)'(off));
		raddr   = cnt_q[0] ? dn_addr : up_addr;
	end

	lsr_ram #(
		.WIDTH(32),
		.DEPTH(W)
	) u_window (
		.clk  (clk),
		.we   (src_acc && push_ok),
		.waddr(wp_q),
		.wdata(src_data.voxel_value),
		.re   (ram_re),
		.raddr(raddr),
		.rdata(rdata)
	);

	lsr_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.radicand(sum_q),
		.done    (sq_done),
		.root    (sq_root)
	);

	// Sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lsr_pkg::ST_IDLE:  if (src_acc && emit) state_d = lsr_pkg::ST_READ;
			lsr_pkg::ST_READ:  if (cnt_q == 3'd7) state_d = lsr_pkg::ST_DIFF;
			lsr_pkg::ST_DIFF:  if (cnt_q == 3'd5) state_d = lsr_pkg::ST_TERM;
			lsr_pkg::ST_TERM:  if (cnt_q == 3'd3) state_d = lsr_pkg::ST_ROOT;
			lsr_pkg::ST_ROOT:  if (sq_done) state_d = lsr_pkg::ST_SCALE;
			lsr_pkg::ST_SCALE: state_d = lsr_pkg::ST_OUT;
			lsr_pkg::ST_OUT:   if (!res_valid_q || !res_stall) state_d = lsr_pkg::ST_IDLE;
			default:           state_d = lsr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		src_stall = (state_q != lsr_pkg::ST_IDLE);
		ram_re    = (state_q == lsr_pkg::ST_READ) && (cnt_q != 3'd7);
		sq_start  = (state_q == lsr_pkg::ST_ROOT) && (cnt_q == 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lsr_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else if (state_q == lsr_pkg::ST_ROOT) begin
				cnt_q <= 3'd1;
			end else if (state_q != lsr_pkg::ST_IDLE && state_q != lsr_pkg::ST_OUT) begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	// Scaled one-sided (forward or backward) differences, one per cycle.
	logic [1:0]         axis;
	logic               first_a, last_a, fw_form;
	logic [31:0]        c_val, nxt, prv;
	logic signed [32:0] diff;
	logic               dneg;
	logic [32:0]        dmag;
	logic [64:0]        dprod;
	logic [48:0]        dround;
	logic [31:0]        dsat;
	logic signed [32:0] dscaled;

	always_comb begin
		axis  = cnt_q[2:1];
		c_val = nb_q[0];
		unique case (axis)
			2'd0: begin
				first_a = (pi_q == '0);
				last_a  = (pi_q == sx_q - XW'(1));
				nxt     = nb_q[2];
				prv     = nb_q[1];
			end
			2'd1: begin
				first_a = (pj_q == '0);
				last_a  = (pj_q == sy_q - YW'(1));
				nxt     = nb_q[4];
				prv     = nb_q[3];
			end
			default: begin
				first_a = (pk_q == '0);
				last_a  = (pk_q == sz_q - ZW'(1));
				nxt     = nb_q[6];
				prv     = nb_q[5];
			end
		endcase
		fw_form = first_a || (!last_a && !cnt_q[0]);
		diff    = fw_form ? $signed({nxt[31], nxt}) - $signed({c_val[31], c_val})
			: $signed({c_val[31], c_val}) - $signed({prv[31], prv});
		dneg    = diff[32];
		dmag    = dneg ? 33'(-diff) : 33'(diff);
		dprod   = 65'(dmag) * 65'(inv_q);
		dround  = 49'((dprod + lsr_pkg::HALF_LSB) >> 16);
		dsat    = (dround > 49'h80000000) ? 32'h80000000 : dround[31:0];
		dscaled = dneg ? -$signed({1'b0, dsat}) : $signed({1'b0, dsat});
	end

	// Upwind selection per axis.
	logic               pos;
	logic signed [32:0] fw, bw;
	logic [31:0]        ua, ub, um;

	always_comb begin
		pos = !c_val[31];
		fw  = sd_q[{cnt_q[1:0], 1'b0}];
		bw  = sd_q[{cnt_q[1:0], 1'b1}];
		if (pos) begin
			ua = (bw > 0) ? bw[31:0] : 32'd0;
			ub = (fw < 0) ? 32'(-fw) : 32'd0;
		end else begin
			ua = (fw > 0) ? fw[31:0] : 32'd0;
			ub = (bw < 0) ? 32'(-bw) : 32'd0;
		end
		um = (ua > ub) ? ua : ub;
	end

	// Step on the gradient magnitude error.
	logic signed [33:0] hval;
	logic [32:0]        hmag;
	logic [64:0]        hprod;
	logic signed [63:0] vext, rsum;
	logic [31:0]        rsat;

	always_comb begin
		hval  = $signed({2'b00, sq_root}) - $signed({2'b00, lsr_pkg::ONE_Q16});
		hmag  = hval[33] ? 33'(-hval) : 33'(hval);
		hprod = 65'(hmag) * 65'(ts_q);
		vext  = 64'($signed(c_val));
		rsum  = (hpos_q == pos) ? vext - $signed({15'd0, d_q}) : vext + $signed({15'd0, d_q});
		if (rsum > 64'sd2147483647) begin
			rsat = 32'h7FFFFFFF;
		end else if (rsum < -64'sd2147483648) begin
			rsat = 32'h80000000;
		end else begin
			rsat = rsum[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lsr_pkg::ST_READ && cnt_q != 3'd0) begin
			nb_q[cnt_q - 3'd1] <= rdata;
		end
		if (state_q == lsr_pkg::ST_DIFF) begin
			sd_q[cnt_q] <= dscaled;
		end
		if (state_q == lsr_pkg::ST_TERM) begin
			sq_q <= 64'(um) * 64'(um);
			sum_q <= (cnt_q == 3'd0) ? 64'd0 : sum_q + sq_q;
		end
		if (state_q == lsr_pkg::ST_ROOT && sq_done) begin
			d_q    <= 49'((hprod + lsr_pkg::HALF_LSB) >> 16);
			hpos_q <= !hval[33];
		end
		if (state_q == lsr_pkg::ST_OUT && (!res_valid_q || !res_stall)) begin
			res_q.new_value  <= rsat;
			res_q.last_voxel <= plast_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == lsr_pkg::ST_OUT && (!res_valid_q || !res_stall)) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

`default_nettype wire

[design/lsr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module lsr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8193
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[design/lsr_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none

module lsr_sqrt (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] radicand,
	output      logic        done,
	output      logic [31:0] root
);

	logic [63:0] rem_q;
	logic [63:0] res_q;
	logic [63:0] bit_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] trial;

	assign trial = res_q + bit_q;
	assign done  = done_q;
	assign root  = res_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == 64'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= 64'd0;
			bit_q <= 64'd1 << 62;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

endmodule

`default_nettype wire

[design/lsr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module lsr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic src_valid,
	input wire logic src_stall,
	input wire logic res_valid,
	input wire logic res_stall
);

	// A waiting result beat is held until it is taken.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result beat dropped while stalled");

	// A new result is only produced while the input side is held off.
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(src_stall))
		else $error("result appeared without a busy sequencer");

	// No result can appear in the cycle right after an input beat.
	a_res_latency: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && !src_stall |=> !$rose(res_valid))
		else $error("result appeared too early after an input beat");

endmodule

bind level_set_reinit_step_3d lsr_checker u_lsr_checker (.*);

`default_nettype wire
